// File: rtl/core/assert_macros.svh
// assertion macros used by the top level of the cursor engine
// no dependencies; simulation builds get the checks, synthesis gets empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(name, clk_s, rst_s, expr, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (expr)) else $error(msg);

// property that must hold in the cycle after the trigger
`define ASSERT_NEXT(name, clk_s, rst_s, trig, expr, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (trig) |=> (expr)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(name, clk_s, rst_s, expr, msg)
`define ASSERT_NEXT(name, clk_s, rst_s, trig, expr, msg)

`endif

`endif

// File: rtl/core/tcce_pkg.sv
// types and constants of the text console cursor engine
// no dependencies; used by the interfaces, the step logic and the top level
`default_nettype none

package tcce_pkg;

  // operation codes
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_SET   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // control characters
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // field widths
  localparam int FUNC_W    = 2;
  localparam int BYTE_W    = 8;
  localparam int ADDR_W    = 11;
  localparam int WORD_W    = 16;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;
  // wide enough for row*cols+col at the largest grid (64 x 128)
  localparam int LIN_W     = 13;

  // configuration port
  localparam int          PADDR_W     = 1;
  localparam int          PDATA_W     = 32;
  localparam logic [PADDR_W-1:0] ATTR_ADDR = 1'b0;
  localparam logic [BYTE_W-1:0]  ATTR_RESET = 8'd15;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] character;
    logic [BYTE_W-1:0] new_row;
    logic [BYTE_W-1:0] new_col;
  } cmd_t;

  typedef struct packed {
    logic                 cell_write;
    logic [ADDR_W-1:0]    cell_address;
    logic [WORD_W-1:0]    cell_word;
    logic                 scroll;
    logic                 clear;
    logic [ADDR_W-1:0]    cursor_position;
    logic [ROW_OUT_W-1:0] cursor_row_out;
    logic [COL_OUT_W-1:0] cursor_col_out;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/tcce_cmd_if.sv
// command channel of the cursor engine: valid/ready plus one operation item
// depends on tcce_pkg for field widths
`default_nettype none

interface tcce_cmd_if import tcce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] character;
  logic [BYTE_W-1:0] new_row;
  logic [BYTE_W-1:0] new_col;

  modport source (output valid, func, character, new_row, new_col, input ready);
  modport sink   (input valid, func, character, new_row, new_col, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tcce_res_if.sv
// result channel of the cursor engine: valid/ready plus one result item
// depends on tcce_pkg for field widths
`default_nettype none

interface tcce_res_if import tcce_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 cell_write;
  logic [ADDR_W-1:0]    cell_address;
  logic [WORD_W-1:0]    cell_word;
  logic                 scroll;
  logic                 clear;
  logic [ADDR_W-1:0]    cursor_position;
  logic [ROW_OUT_W-1:0] cursor_row_out;
  logic [COL_OUT_W-1:0] cursor_col_out;

  modport source (output valid, cell_write, cell_address, cell_word, scroll, clear,
                  cursor_position, cursor_row_out, cursor_col_out, input ready);
  modport sink   (input valid, cell_write, cell_address, cell_word, scroll, clear,
                  cursor_position, cursor_row_out, cursor_col_out, output ready);
endinterface

`default_nettype wire

// File: rtl/core/text_console_cursor_engine.sv
// top level of the text console cursor engine: channels, config port, cursor state
// depends on tcce_pkg, tcce_cmd_if, tcce_res_if, tcce_step and assert_macros.svh
//
//   channel  | dir | handshake         | item
//   ---------+-----+-------------------+---------------------------------------------
//   cmd      | in  | valid/ready       | func, character, new_row, new_col
//   res      | out | valid/ready       | cell write, scroll, clear, cursor
//   apb      | in  | psel/penable      | text_attribute at byte address 0
//
// one item per cycle sustained while res is ready; res valid rises once the item has
// passed the input register and then the result register fed by tcce_step
// the cursor registers update at the same edge that loads the result
// register, so the next item sees the new cursor with no bubble
// rst clears the valid flags, the cursor (row 0, column 0) and the attribute (15)
// a stall on res holds the result register; cmd still fills the input register if it
// is empty, after which cmd.ready drops until res moves
`default_nettype none
`include "assert_macros.svh"

module text_console_cursor_engine import tcce_pkg::*; #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic               clk,
  input  logic               rst,
  tcce_cmd_if.sink           cmd,
  tcce_res_if.source         res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);

  // input register
  logic          in_valid;
  cmd_t          in_data;

  // result register
  logic          out_valid;
  res_t          out_data;

  // cursor state and attribute
  logic [RW-1:0] row_reg;
  logic [CW-1:0] col_reg;
  logic [RW-1:0] row_next;
  logic [CW-1:0] col_next;
  logic [BYTE_W-1:0] attr;

  res_t          step_res;
  logic          adv;
  logic          cfg_wr;

  // item moves from the input register into the result register
  assign adv       = in_valid && (!out_valid || res.ready);
  assign cmd.ready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_data.func      <= cmd.func;
      in_data.character <= cmd.character;
      in_data.new_row   <= cmd.new_row;
      in_data.new_col   <= cmd.new_col;
    end
  end

  tcce_step #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_step (
    .row      (row_reg),
    .col      (col_reg),
    .attr     (attr),
    .cmd      (in_data),
    .row_next (row_next),
    .col_next (col_next),
    .res      (step_res)
  );

  // cursor follows each item as it completes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_reg <= '0;
      col_reg <= '0;
    end else if (adv) begin
      row_reg <= row_next;
      col_reg <= col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || res.ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= step_res;
    end
  end

  assign res.valid           = out_valid;
  assign res.cell_write      = out_data.cell_write;
  assign res.cell_address    = out_data.cell_address;
  assign res.cell_word       = out_data.cell_word;
  assign res.scroll          = out_data.scroll;
  assign res.clear           = out_data.clear;
  assign res.cursor_position = out_data.cursor_position;
  assign res.cursor_row_out  = out_data.cursor_row_out;
  assign res.cursor_col_out  = out_data.cursor_col_out;

  // configuration port, pready tied high so a transfer never waits
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (cfg_wr && (paddr == ATTR_ADDR)) begin
      attr <= pwdata[BYTE_W-1:0];
    end
  end

  assign prdata = (paddr == ATTR_ADDR) ? PDATA_W'(attr) : '0;

  // cursor never leaves the grid
  `ASSERT_ALWAYS(a_row_range, clk, rst,
    row_reg < RW'(ROWS - 1) || row_reg == RW'(ROWS - 1), "cursor row out of range")
  `ASSERT_ALWAYS(a_col_range, clk, rst,
    col_reg < CW'(COLS - 1) || col_reg == CW'(COLS - 1), "cursor column out of range")
  // clear sends the cursor home
  `ASSERT_NEXT(a_clear_home, clk, rst, adv && in_data.func == FUNC_CLEAR,
    row_reg == '0 && col_reg == '0, "clear left cursor away from home")
  // a scroll always lands at column 0
  `ASSERT_ALWAYS(a_scroll_col, clk, rst,
    !(out_valid && out_data.scroll) || out_data.cursor_col_out == '0, "scroll off column 0")
  // a held input item is neither dropped nor overwritten
  `ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !adv,
    in_valid && $stable(in_data), "stalled input item lost")

endmodule

`default_nettype wire

// File: rtl/core/tcce_step.sv
// next-cursor and cell-write logic for one operation item
// depends on tcce_pkg; purely combinational, instanced by the top level
`default_nettype none

module tcce_step import tcce_pkg::*; #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic [$clog2(ROWS)-1:0] row,
  input  logic [$clog2(COLS)-1:0] col,
  input  logic [BYTE_W-1:0]       attr,
  input  cmd_t                    cmd,
  output logic [$clog2(ROWS)-1:0] row_next,
  output logic [$clog2(COLS)-1:0] col_next,
  output res_t                    res
);

  localparam int RW  = $clog2(ROWS);
  localparam int CW  = $clog2(COLS);
  localparam int RW1 = RW + 1;
  localparam int CW1 = CW + 1;
  localparam logic [RW:0] ROWS_V = RW1'(ROWS);
  localparam logic [CW:0] COLS_V = CW1'(COLS);
  localparam logic [RW:0] LAST_ROW = RW1'(ROWS - 1);

  logic [RW:0]        r_w;
  logic [CW:0]        c_w;
  logic [CW:0]        tab_sum;
  logic [CW-1:0]      cell_col;
  logic [BYTE_W-1:0]  word_ch;
  logic               wr;
  logic               scr;
  logic               clr;
  logic [LIN_W-1:0]   cell_lin;
  logic [LIN_W-1:0]   cur_lin;

  always_comb begin
    r_w      = {1'b0, row};
    c_w      = {1'b0, col};
    tab_sum  = c_w + CW1'(8);
    cell_col = col;
    word_ch  = cmd.character;
    wr       = 1'b0;
    scr      = 1'b0;
    clr      = 1'b0;
    case (cmd.func)
      FUNC_PUT: begin
        case (cmd.character)
          CH_NEWLINE: begin
            r_w = r_w + RW1'(1);
            c_w = '0;
          end
          CH_RETURN: begin
            c_w = '0;
          end
          CH_BACKSPACE: begin
            if (col != '0) begin
              c_w      = c_w - CW1'(1);
              cell_col = col - CW'(1);
              word_ch  = CH_SPACE;
              wr       = 1'b1;
            end
          end
          CH_TAB: begin
            c_w = {tab_sum[CW:3], 3'b000};
            if (c_w >= COLS_V) begin
              c_w = '0;
              r_w = r_w + RW1'(1);
            end
          end
          default: begin
            wr  = 1'b1;
            c_w = c_w + CW1'(1);
          end
        endcase
        // line end
        if (c_w >= COLS_V) begin
          c_w = '0;
          r_w = r_w + RW1'(1);
        end
        // screen end
        if (r_w >= ROWS_V) begin
          scr = 1'b1;
          r_w = LAST_ROW;
          c_w = '0;
        end
      end
      FUNC_SET: begin
        if (cmd.new_row < BYTE_W'(ROWS)) begin
          r_w = RW1'(cmd.new_row);
        end
        if (cmd.new_col < BYTE_W'(COLS)) begin
          c_w = CW1'(cmd.new_col);
        end
      end
      FUNC_CLEAR: begin
        clr = 1'b1;
        r_w = '0;
        c_w = '0;
      end
      default: begin
      end
    endcase
  end

  assign row_next = r_w[RW-1:0];
  assign col_next = c_w[CW-1:0];

  assign cell_lin = LIN_W'(row) * LIN_W'(COLS) + LIN_W'(cell_col);
  assign cur_lin  = LIN_W'(row_next) * LIN_W'(COLS) + LIN_W'(col_next);

  always_comb begin
    res.cell_write      = wr;
    res.cell_address    = wr ? cell_lin[ADDR_W-1:0] : '0;
    res.cell_word       = wr ? {attr, word_ch} : '0;
    res.scroll          = scr;
    res.clear           = clr;
    res.cursor_position = cur_lin[ADDR_W-1:0];
    res.cursor_row_out  = ROW_OUT_W'(row_next);
    res.cursor_col_out  = COL_OUT_W'(col_next);
  end

endmodule

`default_nettype wire
